FILE: sv/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed in %m");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed in %m");

// Next-cycle implication that is also checked through reset.
`define ASSERT_NXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed in %m");

`endif

FILE: sv/kmh_pkg.sv
`default_nettype none

package kmh_pkg;

   localparam int IN_KEY_WIDTH    = 32;
   localparam int RUN_WIDTH       = 4;
   localparam int OCC_WIDTH       = 5;
   localparam int FUNC_WIDTH      = 2;
   localparam int STATUS_WIDTH    = 2;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 2;

   localparam logic [FUNC_WIDTH-1:0] FUNC_PUSH     = 2'd0;
   localparam logic [FUNC_WIDTH-1:0] FUNC_POP_PUSH = 2'd1;

   localparam logic [STATUS_WIDTH-1:0] STATUS_PUSHED = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_POPPED = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_EMPTY  = 2'd2;
   localparam logic [STATUS_WIDTH-1:0] STATUS_FULL   = 2'd3;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KEY_COUNT   = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FIRST_DESC  = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SECOND_DESC = 2'd2;

   localparam logic [CSR_DATA_WIDTH-1:0] KEY_COUNT_RESET = 2'd1;

   typedef struct packed {
      logic take;
      logic start;
      logic push_init;
      logic pop_load;
      logic down_step;
      logic up_step;
      logic place;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic is_push;
      logic full;
      logic cnt_zero;
      logic cnt_one;
      logic refill;
      logic down_done;
      logic up_done;
      logic out_free;
   } sts_type;

endpackage

`default_nettype wire

FILE: sv/kmh_req_if.sv
`default_nettype none

interface kmh_req_if;
   logic                                   valid;
   logic                                   ready;
   logic [kmh_pkg::FUNC_WIDTH-1:0]         func;
   logic signed [kmh_pkg::IN_KEY_WIDTH-1:0] key_a;
   logic                                   key_a_null;
   logic signed [kmh_pkg::IN_KEY_WIDTH-1:0] key_b;
   logic                                   key_b_null;
   logic [kmh_pkg::RUN_WIDTH-1:0]          source_run;

   modport source (output valid, func, key_a, key_a_null, key_b, key_b_null, source_run,
                   input ready);
   modport sink (input valid, func, key_a, key_a_null, key_b, key_b_null, source_run,
                 output ready);
endinterface

`default_nettype wire

FILE: sv/kmh_rsp_if.sv
`default_nettype none

interface kmh_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic [kmh_pkg::STATUS_WIDTH-1:0]       status;
   logic signed [kmh_pkg::IN_KEY_WIDTH-1:0] out_key_a;
   logic                                   out_key_a_null;
   logic signed [kmh_pkg::IN_KEY_WIDTH-1:0] out_key_b;
   logic                                   out_key_b_null;
   logic [kmh_pkg::RUN_WIDTH-1:0]          out_run;
   logic [kmh_pkg::OCC_WIDTH-1:0]          occupancy;

   modport source (output valid, status, out_key_a, out_key_a_null, out_key_b,
                   out_key_b_null, out_run, occupancy,
                   input ready);
   modport sink (input valid, status, out_key_a, out_key_a_null, out_key_b,
                 out_key_b_null, out_run, occupancy,
                 output ready);
endinterface

`default_nettype wire

FILE: sv/kmh_controller.sv
`default_nettype none

module kmh_controller (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  kmh_pkg::sts_type  sts,
   output kmh_pkg::cmd_type  cmd
);

   typedef enum logic [7:0] {
      ST_IDLE     = 8'b0000_0001,
      ST_START    = 8'b0000_0010,
      ST_POP_LOAD = 8'b0000_0100,
      ST_DOWN     = 8'b0000_1000,
      ST_UP       = 8'b0001_0000,
      ST_PLACE    = 8'b0010_0000,
      ST_PUSH     = 8'b0100_0000,
      ST_FINISH   = 8'b1000_0000
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.take = 1'b1;
               state_in = ST_START;
            end
         end
         ST_START: begin
            cmd.start = 1'b1;
            if (sts.is_push) begin
               if (sts.full) begin
                  state_in = ST_FINISH;
               end else if (sts.cnt_zero) begin
                  state_in = ST_PLACE;
               end else begin
                  state_in = ST_UP;
               end
            end else if (sts.cnt_zero) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_POP_LOAD;
            end
         end
         ST_POP_LOAD: begin
            cmd.pop_load = 1'b1;
            if (sts.cnt_zero) begin
               state_in = sts.refill ? ST_PUSH : ST_FINISH;
            end else if (sts.cnt_one) begin
               state_in = ST_PLACE;
            end else begin
               state_in = ST_DOWN;
            end
         end
         ST_DOWN: begin
            cmd.down_step = 1'b1;
            if (sts.down_done) begin
               state_in = ST_PLACE;
            end
         end
         ST_UP: begin
            cmd.up_step = 1'b1;
            if (sts.up_done) begin
               state_in = ST_PLACE;
            end
         end
         ST_PLACE: begin
            cmd.place = 1'b1;
            state_in  = sts.refill ? ST_PUSH : ST_FINISH;
         end
         ST_PUSH: begin
            cmd.push_init = 1'b1;
            state_in      = sts.cnt_zero ? ST_PLACE : ST_UP;
         end
         ST_FINISH: begin
            if (sts.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

FILE: sv/kmh_datapath.sv
`default_nettype none

module kmh_datapath #(
   parameter int CAPACITY  = 16,
   parameter int KEY_WIDTH = 32
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  kmh_pkg::cmd_type                        cmd,
   output kmh_pkg::sts_type                        sts,
   input  logic                                    csr_write_en,
   input  logic [kmh_pkg::CSR_INDEX_WIDTH-1:0]     csr_index,
   input  logic [kmh_pkg::CSR_DATA_WIDTH-1:0]      csr_data,
   input  logic [kmh_pkg::FUNC_WIDTH-1:0]          req_func,
   input  logic signed [kmh_pkg::IN_KEY_WIDTH-1:0] req_key_a,
   input  logic                                    req_key_a_null,
   input  logic signed [kmh_pkg::IN_KEY_WIDTH-1:0] req_key_b,
   input  logic                                    req_key_b_null,
   input  logic [kmh_pkg::RUN_WIDTH-1:0]           req_source_run,
   input  logic                                    rsp_ready,
   output logic                                    rsp_valid,
   output logic [kmh_pkg::STATUS_WIDTH-1:0]        rsp_status,
   output logic signed [kmh_pkg::IN_KEY_WIDTH-1:0] rsp_out_key_a,
   output logic                                    rsp_out_key_a_null,
   output logic signed [kmh_pkg::IN_KEY_WIDTH-1:0] rsp_out_key_b,
   output logic                                    rsp_out_key_b_null,
   output logic [kmh_pkg::RUN_WIDTH-1:0]           rsp_out_run,
   output logic [kmh_pkg::OCC_WIDTH-1:0]           rsp_occupancy
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int XW = AW + 2;
   localparam int OW = kmh_pkg::OCC_WIDTH;
   localparam int KW = kmh_pkg::IN_KEY_WIDTH;

   typedef struct packed {
      logic [KEY_WIDTH-1:0]          key_a;
      logic [KEY_WIDTH-1:0]          key_b;
      logic [1:0]                    nulls;
      logic [kmh_pkg::RUN_WIDTH-1:0] run;
   } entry_type;

   // Returns {less, greater} for one key, with direction and null placement applied.
   function automatic logic [1:0] key_order(
      input logic [KEY_WIDTH-1:0] ka,
      input logic                 na,
      input logic [KEY_WIDTH-1:0] kb,
      input logic                 nb,
      input logic                 desc
   );
      logic lt;
      logic gt;
      lt = 1'b0;
      gt = 1'b0;
      if (na != nb) begin
         lt = na ? desc : !desc;
         gt = na ? !desc : desc;
      end else if (!na) begin
         if ($signed(ka) < $signed(kb)) begin
            lt = !desc;
            gt = desc;
         end else if ($signed(ka) > $signed(kb)) begin
            lt = desc;
            gt = !desc;
         end
      end
      return {lt, gt};
   endfunction

   function automatic logic sorts_before(
      input entry_type  x,
      input entry_type  y,
      input logic [1:0] kc,
      input logic       desc_a,
      input logic       desc_b
   );
      logic [1:0] r1;
      logic [1:0] r2;
      logic       res;
      r1  = key_order(x.key_a, x.nulls[0], y.key_a, y.nulls[0], desc_a);
      r2  = key_order(x.key_b, x.nulls[1], y.key_b, y.nulls[1], desc_b);
      res = 1'b0;
      if (kc != 2'd0) begin
         if (r1 != 2'b00) begin
            res = r1[1];
         end else if (kc != 2'd1) begin
            res = r2[1];
         end
      end
      return res;
   endfunction

   entry_type mem [CAPACITY];

   logic [kmh_pkg::CSR_DATA_WIDTH-1:0] key_count_ff, key_count_in;
   logic                               desc_a_ff, desc_a_in;
   logic                               desc_b_ff, desc_b_in;
   logic [kmh_pkg::FUNC_WIDTH-1:0]     func_ff, func_in;
   entry_type                          req_ent_ff, req_ent_in;
   entry_type                          x_ff, x_in;
   entry_type                          pop_ff, pop_in;
   entry_type                          rd_a_ff, rd_b_ff;
   logic [AW-1:0]                      idx_ff, idx_in;
   logic [CW-1:0]                      count_ff, count_in;
   logic                               refill_ff, refill_in;
   logic [kmh_pkg::STATUS_WIDTH-1:0]   status_ff, status_in;

   logic                               rsp_valid_ff, rsp_valid_in;
   logic [kmh_pkg::STATUS_WIDTH-1:0]   rsp_status_ff, rsp_status_in;
   logic [KW-1:0]                      rsp_key_a_ff, rsp_key_a_in;
   logic [KW-1:0]                      rsp_key_b_ff, rsp_key_b_in;
   logic [1:0]                         rsp_nulls_ff, rsp_nulls_in;
   logic [kmh_pkg::RUN_WIDTH-1:0]      rsp_run_ff, rsp_run_in;
   logic [OW-1:0]                      rsp_occ_ff, rsp_occ_in;

   logic [63:0]     in_key_a_wide;
   logic [63:0]     in_key_b_wide;
   logic [63:0]     out_key_a_wide;
   logic [63:0]     out_key_b_wide;
   logic [CW+OW-1:0] occ_wide;
   entry_type       in_ent;

   logic [XW-1:0]   count_x;
   logic            is_push;
   logic            full;
   logic            cnt_zero;
   logic            do_push;
   logic            do_pop;
   logic [AW-1:0]   push_par;
   logic [AW-1:0]   pop_last;

   logic [XW-1:0]   l_x;
   logic [XW-1:0]   r_x;
   logic            r_ok;
   logic            c_lx;
   logic            c_rx;
   logic            c_rl;
   logic            take_r;
   logic            down_stop;
   logic [XW-1:0]   child_x;
   logic [AW-1:0]   child;
   entry_type       best_ent;
   logic [XW-1:0]   gl_x;
   logic [XW-1:0]   gr_x;
   logic            down_leaf;

   logic [AW-1:0]   par;
   logic [AW-1:0]   par_par;
   logic            up_lt;

   logic [AW-1:0]   rd_a_addr;
   logic [AW-1:0]   rd_b_addr;
   logic            wr_en;
   logic [AW-1:0]   wr_addr;
   entry_type       wr_data;

   // Input keys keep their low KEY_WIDTH bits; results are sign-extended back.
   assign in_key_a_wide  = 64'(req_key_a);
   assign in_key_b_wide  = 64'(req_key_b);
   assign in_ent.key_a   = in_key_a_wide[KEY_WIDTH-1:0];
   assign in_ent.key_b   = in_key_b_wide[KEY_WIDTH-1:0];
   assign in_ent.nulls   = {req_key_b_null, req_key_a_null};
   assign in_ent.run     = req_source_run;

   assign out_key_a_wide = 64'($signed(pop_ff.key_a));
   assign out_key_b_wide = 64'($signed(pop_ff.key_b));
   assign occ_wide       = (CW + OW)'(count_ff);

   assign count_x  = XW'(count_ff);
   assign is_push  = (func_ff == kmh_pkg::FUNC_PUSH);
   assign full     = (count_x >= XW'(CAPACITY));
   assign cnt_zero = (count_ff == '0);
   assign do_push  = (cmd.start && is_push && !full) || cmd.push_init;
   assign do_pop   = cmd.start && !is_push && !cnt_zero;
   assign push_par = AW'((count_ff - CW'(1)) >> 1);
   assign pop_last = AW'(count_ff - CW'(1));

   // Sift-down step: the moving entry is held in x_ff, both children arrive
   // from the two read ports, and three comparisons pick the smallest.
   assign l_x       = {1'b0, idx_ff, 1'b1};
   assign r_x       = l_x + XW'(1);
   assign r_ok      = (r_x < count_x);
   assign c_lx      = sorts_before(rd_a_ff, x_ff, key_count_ff, desc_a_ff, desc_b_ff);
   assign c_rx      = sorts_before(rd_b_ff, x_ff, key_count_ff, desc_a_ff, desc_b_ff);
   assign c_rl      = sorts_before(rd_b_ff, rd_a_ff, key_count_ff, desc_a_ff, desc_b_ff);
   assign take_r    = r_ok && (c_lx ? c_rl : c_rx);
   assign down_stop = !c_lx && !take_r;
   assign child_x   = take_r ? r_x : l_x;
   assign child     = child_x[AW-1:0];
   assign best_ent  = take_r ? rd_b_ff : rd_a_ff;
   assign gl_x      = {1'b0, child, 1'b1};
   assign gr_x      = gl_x + XW'(1);
   assign down_leaf = (gl_x >= count_x);

   // Sift-up step: the parent arrives on read port A.
   assign par     = (idx_ff - AW'(1)) >> 1;
   assign par_par = (par - AW'(1)) >> 1;
   assign up_lt   = sorts_before(x_ff, rd_a_ff, key_count_ff, desc_a_ff, desc_b_ff);

   assign sts.is_push   = is_push;
   assign sts.full      = full;
   assign sts.cnt_zero  = cnt_zero;
   assign sts.cnt_one   = (count_ff == CW'(1));
   assign sts.refill    = refill_ff;
   assign sts.down_done = down_stop || down_leaf;
   assign sts.up_done   = !up_lt || (par == '0);
   assign sts.out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rd_a_addr = '0;
      rd_b_addr = '0;
      if (do_push) begin
         rd_a_addr = push_par;
      end else if (do_pop) begin
         rd_b_addr = pop_last;
      end else if (cmd.pop_load) begin
         rd_a_addr = AW'(1);
         rd_b_addr = AW'(2);
      end else if (cmd.down_step) begin
         rd_a_addr = gl_x[AW-1:0];
         rd_b_addr = gr_x[AW-1:0];
      end else if (cmd.up_step) begin
         rd_a_addr = par_par;
      end
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = idx_ff;
      wr_data = x_ff;
      if (cmd.place) begin
         wr_en = 1'b1;
      end else if (cmd.down_step && !down_stop) begin
         wr_en   = 1'b1;
         wr_data = best_ent;
      end else if (cmd.up_step && up_lt) begin
         wr_en   = 1'b1;
         wr_data = rd_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem[rd_a_addr];
      rd_b_ff <= mem[rd_b_addr];
   end

   always_comb begin
      key_count_in  = key_count_ff;
      desc_a_in     = desc_a_ff;
      desc_b_in     = desc_b_ff;
      func_in       = func_ff;
      req_ent_in    = req_ent_ff;
      x_in          = x_ff;
      pop_in        = pop_ff;
      idx_in        = idx_ff;
      count_in      = count_ff;
      refill_in     = refill_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_key_a_in  = rsp_key_a_ff;
      rsp_key_b_in  = rsp_key_b_ff;
      rsp_nulls_in  = rsp_nulls_ff;
      rsp_run_in    = rsp_run_ff;
      rsp_occ_in    = rsp_occ_ff;

      if (csr_write_en) begin
         unique case (csr_index)
            kmh_pkg::CSR_KEY_COUNT:   key_count_in = csr_data;
            kmh_pkg::CSR_FIRST_DESC:  desc_a_in    = csr_data[0];
            kmh_pkg::CSR_SECOND_DESC: desc_b_in    = csr_data[0];
            default: begin
            end
         endcase
      end

      if (cmd.take) begin
         func_in    = req_func;
         req_ent_in = in_ent;
      end

      if (cmd.start) begin
         if (is_push) begin
            status_in = full ? kmh_pkg::STATUS_FULL : kmh_pkg::STATUS_PUSHED;
         end else begin
            status_in = cnt_zero ? kmh_pkg::STATUS_EMPTY : kmh_pkg::STATUS_POPPED;
         end
      end

      if (do_push) begin
         idx_in    = AW'(count_ff);
         count_in  = count_ff + CW'(1);
         x_in      = req_ent_ff;
         refill_in = 1'b0;
      end else if (do_pop) begin
         count_in  = count_ff - CW'(1);
         refill_in = (func_ff == kmh_pkg::FUNC_POP_PUSH);
      end else if (cmd.pop_load) begin
         pop_in = rd_a_ff;
         x_in   = rd_b_ff;
         idx_in = '0;
      end else if (cmd.down_step && !down_stop) begin
         idx_in = child;
      end else if (cmd.up_step && up_lt) begin
         idx_in = par;
      end

      if (cmd.finish) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = status_ff;
         rsp_occ_in    = occ_wide[OW-1:0];
         if (status_ff == kmh_pkg::STATUS_POPPED) begin
            rsp_key_a_in = out_key_a_wide[KW-1:0];
            rsp_key_b_in = out_key_b_wide[KW-1:0];
            rsp_nulls_in = pop_ff.nulls;
            rsp_run_in   = pop_ff.run;
         end else begin
            rsp_key_a_in = '0;
            rsp_key_b_in = '0;
            rsp_nulls_in = '0;
            rsp_run_in   = '0;
         end
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_count_ff <= kmh_pkg::KEY_COUNT_RESET;
         desc_a_ff    <= 1'b0;
         desc_b_ff    <= 1'b0;
         count_ff     <= '0;
         refill_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         key_count_ff <= key_count_in;
         desc_a_ff    <= desc_a_in;
         desc_b_ff    <= desc_b_in;
         count_ff     <= count_in;
         refill_ff    <= refill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      req_ent_ff    <= req_ent_in;
      x_ff          <= x_in;
      pop_ff        <= pop_in;
      idx_ff        <= idx_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_key_a_ff  <= rsp_key_a_in;
      rsp_key_b_ff  <= rsp_key_b_in;
      rsp_nulls_ff  <= rsp_nulls_in;
      rsp_run_ff    <= rsp_run_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_out_key_a      = rsp_key_a_ff;
   assign rsp_out_key_a_null = rsp_nulls_ff[0];
   assign rsp_out_key_b      = rsp_key_b_ff;
   assign rsp_out_key_b_null = rsp_nulls_ff[1];
   assign rsp_out_run        = rsp_run_ff;
   assign rsp_occupancy      = rsp_occ_ff;

endmodule

`default_nettype wire

FILE: sv/kway_merge_min_heap.sv
// Binary min-heap for a k-way merge of sorted runs.
// req_ch carries one operation per transfer: push an entry, pop the minimum
// and push a refill entry, or pop only. rsp_ch returns exactly one result per
// operation: a status, the popped entry (zero unless an entry was popped) and
// the occupancy afterward. The csr_ port sets the key count and the direction
// of each key; write it only while no operation is in flight.
// Operations run one at a time. A push into a full heap or a pop of an empty
// heap returns its result without touching the entry memory. A push into an
// empty heap places the entry directly; any other push takes up to one compare
// step per heap level on the way up. A pop of one or two entries needs no
// compare step; a larger pop takes up to one compare step per heap level on the
// way down, and a refill adds its own compare steps on the way up. The two read
// ports of the entry memory let each compare step cover one heap level.
// The result sits in an output register, so the next request is taken at the
// edge after the result is loaded, even while the receiver stalls; a further
// result then waits until the register is free.
// Reset empties the heap and restores one ascending key; entry memory is not
// cleared and needs no sweep.
`default_nettype none

module kway_merge_min_heap #(
   parameter int CAPACITY  = 16,
   parameter int KEY_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   kmh_req_if.sink                             req_ch,
   kmh_rsp_if.source                           rsp_ch,
   input  logic                                csr_write_en,
   input  logic [kmh_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [kmh_pkg::CSR_DATA_WIDTH-1:0]  csr_data
);

   kmh_pkg::cmd_type cmd;
   kmh_pkg::sts_type sts;

   kmh_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   kmh_datapath #(
      .CAPACITY  (CAPACITY),
      .KEY_WIDTH (KEY_WIDTH)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .csr_write_en       (csr_write_en),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .req_func           (req_ch.func),
      .req_key_a          (req_ch.key_a),
      .req_key_a_null     (req_ch.key_a_null),
      .req_key_b          (req_ch.key_b),
      .req_key_b_null     (req_ch.key_b_null),
      .req_source_run     (req_ch.source_run),
      .rsp_ready          (rsp_ch.ready),
      .rsp_valid          (rsp_ch.valid),
      .rsp_status         (rsp_ch.status),
      .rsp_out_key_a      (rsp_ch.out_key_a),
      .rsp_out_key_a_null (rsp_ch.out_key_a_null),
      .rsp_out_key_b      (rsp_ch.out_key_b),
      .rsp_out_key_b_null (rsp_ch.out_key_b_null),
      .rsp_out_run        (rsp_ch.out_run),
      .rsp_occupancy      (rsp_ch.occupancy)
   );

endmodule

`default_nettype wire

FILE: sv/kmh_checker.sv
`default_nettype none
`include "assert_macros.svh"

module kmh_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic [kmh_pkg::STATUS_WIDTH-1:0]    rsp_status,
   input logic [kmh_pkg::IN_KEY_WIDTH-1:0]    rsp_out_key_a,
   input logic                                rsp_out_key_a_null,
   input logic [kmh_pkg::IN_KEY_WIDTH-1:0]    rsp_out_key_b,
   input logic                                rsp_out_key_b_null,
   input logic [kmh_pkg::RUN_WIDTH-1:0]       rsp_out_run,
   input logic [kmh_pkg::OCC_WIDTH-1:0]       rsp_occupancy
);

   // A held result keeps its status, first key and occupancy until it is transferred.
   `ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_out_key_a) && $stable(rsp_occupancy))

   // Entry fields are zero unless an entry was popped.
   `ASSERT_IMP(a_zero_fields, clock, reset, rsp_valid && (rsp_status != kmh_pkg::STATUS_POPPED), (rsp_out_key_a == '0) && (rsp_out_key_b == '0) && !rsp_out_key_a_null && !rsp_out_key_b_null && (rsp_out_run == '0))

   // An empty heap reports zero occupancy.
   `ASSERT_IMP(a_empty_occ, clock, reset, rsp_valid && (rsp_status == kmh_pkg::STATUS_EMPTY), rsp_occupancy == '0)

   // No result can appear in the cycle right after a request transfer.
   `ASSERT_NXT(a_no_instant_rsp, clock, reset, req_valid && req_ready, !$rose(rsp_valid))

   // Reset drops any pending result.
   `ASSERT_NXT_ALWAYS(a_reset_clear, clock, reset, !rsp_valid)

endmodule

bind kway_merge_min_heap kmh_checker u_kmh_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_ch.valid),
   .req_ready          (req_ch.ready),
   .rsp_valid          (rsp_ch.valid),
   .rsp_ready          (rsp_ch.ready),
   .rsp_status         (rsp_ch.status),
   .rsp_out_key_a      (rsp_ch.out_key_a),
   .rsp_out_key_a_null (rsp_ch.out_key_a_null),
   .rsp_out_key_b      (rsp_ch.out_key_b),
   .rsp_out_key_b_null (rsp_ch.out_key_b_null),
   .rsp_out_run        (rsp_ch.out_run),
   .rsp_occupancy      (rsp_ch.occupancy)
);

`default_nettype wire

FILE: dv/tb_top.sv
module tb_top;

   localparam int HEAP_DEPTH = 16;
   localparam int MAX_IDLE   = 13;
   localparam int PHASES     = 8;
   localparam int PHASE_OPS  = 190;
   localparam int LONG_HOLD  = 300;

   localparam logic [kmh_pkg::FUNC_WIDTH-1:0] FUNC_POP_ONLY = 2'd2;
   localparam logic [kmh_pkg::FUNC_WIDTH-1:0] FUNC_POP_ALT  = 2'd3;

   typedef struct packed {
      logic [kmh_pkg::FUNC_WIDTH-1:0] func;
      logic signed [31:0]             key_a;
      logic                           key_a_null;
      logic signed [31:0]             key_b;
      logic                           key_b_null;
      logic [kmh_pkg::RUN_WIDTH-1:0]  source_run;
   } heap_op_type;

   typedef struct packed {
      logic [kmh_pkg::STATUS_WIDTH-1:0] status;
      logic signed [31:0]               out_key_a;
      logic                             out_key_a_null;
      logic signed [31:0]               out_key_b;
      logic                             out_key_b_null;
      logic [kmh_pkg::RUN_WIDTH-1:0]    out_run;
      logic [kmh_pkg::OCC_WIDTH-1:0]    occupancy;
   } heap_result_type;

   typedef struct packed {
      logic signed [31:0]            key_a;
      logic                          key_a_null;
      logic signed [31:0]            key_b;
      logic                          key_b_null;
      logic [kmh_pkg::RUN_WIDTH-1:0] run;
   } heap_entry_type;

   logic                                clock;
   logic                                reset;
   logic                                csr_write_en;
   logic [kmh_pkg::CSR_INDEX_WIDTH-1:0] csr_index;
   logic [kmh_pkg::CSR_DATA_WIDTH-1:0]  csr_data;

   kmh_req_if req_ch ();
   kmh_rsp_if rsp_ch ();

   kway_merge_min_heap u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_ch       (req_ch),
      .rsp_ch       (rsp_ch),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   heap_op_type     pending_ops [$];
   heap_result_type awaited_results [$];

   heap_entry_type heap_slot [HEAP_DEPTH];
   int unsigned    heap_size;
   logic [1:0]     cfg_key_count;
   logic           cfg_first_desc;
   logic           cfg_second_desc;

   logic req_taken;
   logic rsp_taken;
   int   src_gap;
   int   sink_gap;
   int   hold_left;
   int   hold_request;
   bit   src_idle_on;
   bit   sink_idle_on;
   int   mismatch_count;

   always #5 clock = ~clock;

   function automatic int compare_key(logic signed [31:0] x, logic x_null,
                                      logic signed [31:0] y, logic y_null, logic desc);
      if (x_null && y_null) return 0;
      if (x_null) return desc ? -1 : 1;
      if (y_null) return desc ? 1 : -1;
      if (x == y) return 0;
      if (x < y) return desc ? 1 : -1;
      return desc ? -1 : 1;
   endfunction

   function automatic bit ranks_first(heap_entry_type x, heap_entry_type y);
      int r;
      if (cfg_key_count >= 2'd1) begin
         r = compare_key(x.key_a, x.key_a_null, y.key_a, y.key_a_null, cfg_first_desc);
         if (r != 0) return r < 0;
      end
      if (cfg_key_count >= 2'd2) begin
         r = compare_key(x.key_b, x.key_b_null, y.key_b, y.key_b_null, cfg_second_desc);
         if (r != 0) return r < 0;
      end
      return 1'b0;
   endfunction

   function automatic void swap_slots(int x, int y);
      heap_entry_type t;
      t = heap_slot[x];
      heap_slot[x] = heap_slot[y];
      heap_slot[y] = t;
   endfunction

   function automatic void sift_up(int i);
      int p;
      while (i > 0) begin
         p = (i - 1) / 2;
         if (!ranks_first(heap_slot[i], heap_slot[p])) break;
         swap_slots(i, p);
         i = p;
      end
   endfunction

   function automatic void settle_down(int i);
      int best;
      int l;
      int r;
      while (i < int'(heap_size)) begin
         best = i;
         l = 2 * i + 1;
         r = 2 * i + 2;
         if (l < int'(heap_size) && ranks_first(heap_slot[l], heap_slot[best])) best = l;
         if (r < int'(heap_size) && ranks_first(heap_slot[r], heap_slot[best])) best = r;
         if (best == i) break;
         swap_slots(i, best);
         i = best;
      end
   endfunction

   function automatic void heap_insert(heap_op_type op);
      if (heap_size >= HEAP_DEPTH) return;
      heap_slot[heap_size] = {op.key_a, op.key_a_null, op.key_b, op.key_b_null, op.source_run};
      heap_size++;
      sift_up(heap_size - 1);
   endfunction

   function automatic heap_result_type apply_heap_op(heap_op_type op);
      heap_result_type res;
      res = '0;
      if (op.func == kmh_pkg::FUNC_PUSH) begin
         if (heap_size >= HEAP_DEPTH) begin
            res.status = kmh_pkg::STATUS_FULL;
         end else begin
            heap_insert(op);
            res.status = kmh_pkg::STATUS_PUSHED;
         end
      end else if (heap_size == 0) begin
         res.status = kmh_pkg::STATUS_EMPTY;
      end else begin
         res.status         = kmh_pkg::STATUS_POPPED;
         res.out_key_a      = heap_slot[0].key_a;
         res.out_key_a_null = heap_slot[0].key_a_null;
         res.out_key_b      = heap_slot[0].key_b;
         res.out_key_b_null = heap_slot[0].key_b_null;
         res.out_run        = heap_slot[0].run;
         heap_slot[0] = heap_slot[heap_size - 1];
         heap_size--;
         if (heap_size > 0) settle_down(0);
         if (op.func == kmh_pkg::FUNC_POP_PUSH) heap_insert(op);
      end
      res.occupancy = heap_size[kmh_pkg::OCC_WIDTH-1:0];
      return res;
   endfunction

   function automatic heap_op_type make_op(logic [kmh_pkg::FUNC_WIDTH-1:0] func,
                                           logic signed [31:0] ka, logic ka_null,
                                           logic signed [31:0] kb, logic kb_null,
                                           logic [kmh_pkg::RUN_WIDTH-1:0] run);
      return {func, ka, ka_null, kb, kb_null, run};
   endfunction

   function automatic void queue_op(heap_op_type op);
      pending_ops.insert(pending_ops.size(), op);
   endfunction

   function automatic logic signed [31:0] rand_key();
      case ($urandom_range(0, 9))
         0: return 32'sh7fffffff;
         1: return 32'sh80000000;
         2, 3: return $urandom;
         default: return 32'($urandom_range(0, 8)) - 32'd4;
      endcase
   endfunction

   function automatic logic rand_null();
      return $urandom_range(0, 5) == 0;
   endfunction

   task automatic check_field(input string name, input logic signed [63:0] want,
                              input logic signed [63:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   task automatic write_csr(input logic [kmh_pkg::CSR_INDEX_WIDTH-1:0] idx,
                            input logic [kmh_pkg::CSR_DATA_WIDTH-1:0] value);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_data     <= value;
      @(negedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         kmh_pkg::CSR_KEY_COUNT:   cfg_key_count   = value;
         kmh_pkg::CSR_FIRST_DESC:  cfg_first_desc  = value[0];
         kmh_pkg::CSR_SECOND_DESC: cfg_second_desc = value[0];
         default: ;
      endcase
   endtask

   task automatic wait_until_drained();
      @(posedge clock);
      while (pending_ops.size() != 0 || req_ch.valid || awaited_results.size() != 0)
         @(posedge clock);
   endtask

   // A transfer on either channel is seen here at the rising edge; prediction
   // happens at the moment the block accepts the operation.
   always @(posedge clock) begin
      heap_result_type want;
      if (reset) begin
         req_taken <= 1'b0;
         rsp_taken <= 1'b0;
      end else begin
         req_taken <= req_ch.valid && req_ch.ready;
         rsp_taken <= rsp_ch.valid && rsp_ch.ready;
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (awaited_results.size() == 0) begin
               $error("result transfer with no operation outstanding");
               mismatch_count++;
            end else begin
               want = awaited_results.pop_front();
               check_field("status", want.status, rsp_ch.status);
               check_field("out_key_a", $signed(want.out_key_a), $signed(rsp_ch.out_key_a));
               check_field("out_key_a_null", want.out_key_a_null, rsp_ch.out_key_a_null);
               check_field("out_key_b", $signed(want.out_key_b), $signed(rsp_ch.out_key_b));
               check_field("out_key_b_null", want.out_key_b_null, rsp_ch.out_key_b_null);
               check_field("out_run", want.out_run, rsp_ch.out_run);
               check_field("occupancy", want.occupancy, rsp_ch.occupancy);
            end
         end
         if (req_ch.valid && req_ch.ready)
            awaited_results.insert(awaited_results.size(), apply_heap_op({req_ch.func,
               req_ch.key_a, req_ch.key_a_null, req_ch.key_b, req_ch.key_b_null,
               req_ch.source_run}));
      end
   end

   always @(negedge clock) begin
      heap_op_type nxt;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_taken) begin
         if (src_gap > 0) begin
            req_ch.valid <= 1'b0;
            src_gap--;
         end else if (pending_ops.size() > 0) begin
            nxt = pending_ops.pop_front();
            req_ch.func       <= nxt.func;
            req_ch.key_a      <= nxt.key_a;
            req_ch.key_a_null <= nxt.key_a_null;
            req_ch.key_b      <= nxt.key_b;
            req_ch.key_b_null <= nxt.key_b_null;
            req_ch.source_run <= nxt.source_run;
            req_ch.valid      <= 1'b1;
            src_gap = src_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (rsp_taken) sink_gap = sink_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (sink_gap > 0) begin
            sink_gap--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   initial begin
      #6000000;
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      int bias;
      int r;
      logic [kmh_pkg::FUNC_WIDTH-1:0] func;
      logic [kmh_pkg::CSR_DATA_WIDTH-1:0] kc;
      logic da;
      logic db;

      clock = 1'b0;
      reset = 1'b1;
      csr_write_en = 1'b0;
      csr_index = '0;
      csr_data = '0;
      req_ch.valid = 1'b0;
      req_ch.func = kmh_pkg::FUNC_PUSH;
      req_ch.key_a = '0;
      req_ch.key_a_null = 1'b0;
      req_ch.key_b = '0;
      req_ch.key_b_null = 1'b0;
      req_ch.source_run = '0;
      rsp_ch.ready = 1'b0;
      heap_size = 0;
      cfg_key_count = kmh_pkg::KEY_COUNT_RESET;
      cfg_first_desc = 1'b0;
      cfg_second_desc = 1'b0;
      src_gap = 0;
      sink_gap = 0;
      hold_left = 0;
      hold_request = 0;
      src_idle_on = 1'b1;
      sink_idle_on = 1'b1;
      mismatch_count = 0;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Pops of an empty heap, then a full heap with extreme keys, nulls and
      // ties, a push that is dropped, and pops from the full heap.
      queue_op(make_op(FUNC_POP_ONLY, 0, 0, 0, 0, 0));
      queue_op(make_op(FUNC_POP_ALT, 0, 0, 0, 0, 0));
      queue_op(make_op(kmh_pkg::FUNC_POP_PUSH, 7, 0, 7, 0, 4'd9));
      queue_op(make_op(kmh_pkg::FUNC_PUSH, 32'sh7fffffff, 0, 32'sh80000000, 0, 4'd0));
      queue_op(make_op(kmh_pkg::FUNC_PUSH, 32'sh80000000, 0, 32'sh7fffffff, 0, 4'd1));
      queue_op(make_op(kmh_pkg::FUNC_PUSH, 0, 0, -1, 1, 4'd2));
      queue_op(make_op(kmh_pkg::FUNC_PUSH, -1, 0, 0, 0, 4'd3));
      queue_op(make_op(kmh_pkg::FUNC_PUSH, 32'sh7fffffff, 1, 3, 0, 4'd4));
      queue_op(make_op(kmh_pkg::FUNC_PUSH, -1, 1, -1, 1, 4'd5));
      queue_op(make_op(kmh_pkg::FUNC_PUSH, 5, 0, 1, 0, 4'd6));
      queue_op(make_op(kmh_pkg::FUNC_PUSH, 5, 0, 1, 0, 4'd7));
      queue_op(make_op(kmh_pkg::FUNC_PUSH, -5, 0, 32'sh55555555, 0, 4'd8));
      queue_op(make_op(kmh_pkg::FUNC_PUSH, 1, 0, 32'shaaaaaaaa, 0, 4'd9));
      queue_op(make_op(kmh_pkg::FUNC_PUSH, 2, 0, 2, 1, 4'd10));
      queue_op(make_op(kmh_pkg::FUNC_PUSH, 3, 0, -3, 0, 4'd11));
      queue_op(make_op(kmh_pkg::FUNC_PUSH, 4, 0, 4, 1, 4'd12));
      queue_op(make_op(kmh_pkg::FUNC_PUSH, 32'sh7fffffff, 0, 0, 0, 4'd13));
      queue_op(make_op(kmh_pkg::FUNC_PUSH, 32'sh80000000, 0, 0, 0, 4'd14));
      queue_op(make_op(kmh_pkg::FUNC_PUSH, 100, 0, -100, 0, 4'd15));
      queue_op(make_op(kmh_pkg::FUNC_PUSH, 0, 0, 0, 0, 4'd15));
      queue_op(make_op(kmh_pkg::FUNC_POP_PUSH, -7, 0, 8, 0, 4'd11));
      queue_op(make_op(FUNC_POP_ALT, 0, 0, 0, 0, 0));
      queue_op(make_op(FUNC_POP_ONLY, 0, 0, 0, 0, 0));
      wait_until_drained();

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin kc = 2'd1; da = 1'b0; db = 1'b0; end
            1: begin kc = 2'd2; da = 1'b0; db = 1'b0; end
            2: begin kc = 2'd2; da = 1'b1; db = 1'b1; end
            3: begin kc = 2'd2; da = 1'b0; db = 1'b1; end
            4: begin kc = 2'd2; da = 1'b1; db = 1'b0; end
            5: begin kc = 2'd0; da = 1'b0; db = 1'b0; end
            6: begin kc = 2'd3; da = 1'b1; db = 1'b0; end
            default: begin kc = 2'd1; da = 1'b1; db = 1'b1; end
         endcase
         write_csr(kmh_pkg::CSR_KEY_COUNT, kc);
         write_csr(kmh_pkg::CSR_FIRST_DESC, {1'b0, da});
         write_csr(kmh_pkg::CSR_SECOND_DESC, {1'b0, db});
         @(posedge clock);
         src_idle_on  = (phase % 3) != 0;
         sink_idle_on = (phase % 4) != 1;
         if (phase == 2) begin
            // The receiver stops for a long stretch while operations keep
            // coming, so the output register fills and the input stalls.
            src_idle_on  = 1'b0;
            hold_request = LONG_HOLD;
         end

         // Segments alternate between filling, steady merging and draining.
         for (int n = 0; n < PHASE_OPS; n++) begin
            if (n % 20 == 0) bias = $urandom_range(0, 2);
            r = $urandom_range(0, 99);
            case (bias)
               0: func = r < 60 ? kmh_pkg::FUNC_PUSH : r < 85 ? kmh_pkg::FUNC_POP_PUSH :
                         r < 97 ? FUNC_POP_ONLY : FUNC_POP_ALT;
               1: func = r < 15 ? kmh_pkg::FUNC_PUSH : r < 85 ? kmh_pkg::FUNC_POP_PUSH :
                         r < 97 ? FUNC_POP_ONLY : FUNC_POP_ALT;
               default: func = r < 15 ? kmh_pkg::FUNC_PUSH :
                               r < 35 ? kmh_pkg::FUNC_POP_PUSH :
                               r < 95 ? FUNC_POP_ONLY : FUNC_POP_ALT;
            endcase
            queue_op(make_op(func, rand_key(), rand_null(), rand_key(),
                             rand_null(), $urandom_range(0, 15)));
         end
         wait_until_drained();
      end

      repeat (40) @(posedge clock);
      if (mismatch_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

FILE: kway_merge_min_heap.f
+incdir+sv
sv/kmh_pkg.sv
sv/kmh_req_if.sv
sv/kmh_rsp_if.sv
sv/kmh_controller.sv
sv/kmh_datapath.sv
sv/kway_merge_min_heap.sv
sv/kmh_checker.sv
dv/tb_top.sv
